/* src/sapc_pkg.sv */
`default_nettype none

package sapc_pkg;

  localparam int unsigned COUNT_BITS = 12;
  localparam logic [12:0] FULL_SCALE = 13'd4096;

  localparam int unsigned MUL_A_W = 36;
  localparam int unsigned MUL_B_W = 21;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned NUM_W   = 60;
  localparam int unsigned DEN_W   = 40;
  localparam int unsigned DVS_W   = DEN_W - 1 + COUNT_BITS;

  localparam logic signed [MUL_B_W-1:0] US_PER_SEC = 21'sd1000000;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_PWM_FREQ    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SERVO_COUNT = 2'd1;

  localparam logic [2:0] STS_OK          = 3'd0;
  localparam logic [2:0] STS_BAD_ID      = 3'd1;
  localparam logic [2:0] STS_STOP_ACTIVE = 3'd2;
  localparam logic [2:0] STS_NOT_ENABLED = 3'd3;
  localparam logic [2:0] STS_EN_REFUSED  = 3'd4;

  typedef enum logic [2:0] {
    KIND_SET_POS    = 3'd0,
    KIND_SET_ENABLE = 3'd1,
    KIND_ESTOP      = 3'd2,
    KIND_CLEAR_STOP = 3'd3,
    KIND_CONFIGURE  = 3'd4
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_MUL4,
    ST_SIGN,
    ST_DIV,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [2:0]         kind;
    logic [3:0]         servo_id;
    logic signed [15:0] angle_cmd;
    logic               enable_flag;
    logic signed [15:0] min_angle_in;
    logic signed [15:0] max_angle_in;
    logic [15:0]        min_pulse_in;
    logic [15:0]        max_pulse_in;
    logic               invert_in;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         channel;
    logic               pwm_write;
    logic [12:0]        on_count;
    logic [12:0]        off_count;
    logic [2:0]         status;
    logic signed [15:0] position_out;
    logic               enabled_out;
    logic               stopped_out;
    logic               last;
  } out_item_t;

endpackage

`default_nettype wire

/* src/servo_angle_pwm_commander.sv */
// Servo commander: maps per-channel angle commands to 12-bit PWM on/off counts.
// Input channel (in_valid_i/in_ready_o, in_item_i) takes one command item;
// output channel (out_valid_o/out_ready_i, out_item_o) returns its result items,
// the final one flagged by last. Config channel (cfg_valid_i/cfg_ready_o) writes
// register 0 (PWM frequency) or 1 (servo count); it is always ready.
// A set position that the channel may take runs to the result register through
// one shared 36x21 multiplier (four passes) and a restoring divider of up to 13
// steps. Other commands go from decode straight to the result. Emergency stop
// emits one item per channel in use, one per cycle while the receiver takes them.
// One item is in flight at a time: in_ready_o rises once the last result of
// the previous item sits in the output register.
// A stalled receiver holds the output register and the sequencer waits.
// Reset: frequency 50 Hz, 16 channels in use, all limits, positions and
// enables cleared, emergency stop inactive.
`default_nettype none

module servo_angle_pwm_commander
  import sapc_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = 16
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  wire in_item_t        in_item_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output out_item_t            out_item_o,
  input  wire                  cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire [CFG_DAT_W-1:0]  cfg_data_i
);

  localparam int unsigned CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [4:0]  CH_NUM = 5'(NUM_CHANNELS);

  state_e state_q, state_d;

  logic [10:0] freq_q;
  logic [4:0]  count_q;
  logic        stop_q;

  logic signed [15:0] ang_lo_q [NUM_CHANNELS];
  logic signed [15:0] ang_hi_q [NUM_CHANNELS];
  logic [15:0]        pls_lo_q [NUM_CHANNELS];
  logic [15:0]        pls_hi_q [NUM_CHANNELS];
  logic signed [15:0] pos_q    [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] inv_q;
  logic [NUM_CHANNELS-1:0] en_q;

  in_item_t cmd_q;

  logic signed [15:0]        op_pmin_q;
  logic signed [17:0]        op_diff_q;
  logic signed [16:0]        op_d_q;
  logic signed [16:0]        op_pd_q;
  logic signed [MUL_A_W-1:0] acc_q;
  logic signed [NUM_W-1:0]   num_q;
  logic signed [DEN_W-1:0]   den_q;
  logic [NUM_W-2:0]          rem_q;
  logic [DVS_W-1:0]          dvs_q;
  logic [COUNT_BITS-1:0]     quo_q;
  logic [3:0]                div_bit_q;

  logic [3:0]  res_ch_q;
  logic        res_wr_q;
  logic [12:0] res_on_q;
  logic [12:0] res_off_q;
  logic [2:0]  res_sts_q;
  logic        res_last_q;

  logic      out_valid_q;
  out_item_t out_q;

  // decode view of the addressed channel
  logic [4:0]         used_cnt;
  logic [CH_W-1:0]    id_idx;
  logic               id_in_range;
  logic               id_in_use;
  logic               pos_go;
  logic signed [15:0] lo, hi, p_hi, p_cl;
  logic signed [16:0] a_val, dlt, pdiff;
  logic signed [17:0] diff;
  logic               d_zero;

  assign used_cnt    = (count_q < CH_NUM) ? count_q : CH_NUM;
  assign id_idx      = cmd_q.servo_id[CH_W-1:0];
  assign id_in_range = {1'b0, cmd_q.servo_id} < CH_NUM;
  assign id_in_use   = {1'b0, cmd_q.servo_id} < used_cnt;
  assign pos_go      = id_in_use && !stop_q && en_q[id_idx];

  assign lo    = ang_lo_q[id_idx];
  assign hi    = ang_hi_q[id_idx];
  assign p_hi  = (cmd_q.angle_cmd < hi) ? cmd_q.angle_cmd : hi;
  assign p_cl  = (p_hi > lo) ? p_hi : lo;
  assign a_val = inv_q[id_idx] ? -{p_cl[15], p_cl} : {p_cl[15], p_cl};
  assign diff  = {a_val[16], a_val} - {{2{lo[15]}}, lo};
  assign dlt   = {hi[15], hi} - {lo[15], lo};
  assign pdiff = {1'b0, pls_hi_q[id_idx]} - {1'b0, pls_lo_q[id_idx]};
  assign d_zero = (dlt == 17'sd0);

  // shared multiplier
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;

  always_comb begin
    case (state_q)
      ST_MUL1: begin
        mul_a = {{(MUL_A_W-16){1'b0}}, op_pmin_q};
        mul_b = {{(MUL_B_W-17){op_d_q[16]}}, op_d_q};
      end
      ST_MUL2: begin
        mul_a = {{(MUL_A_W-18){op_diff_q[17]}}, op_diff_q};
        mul_b = {{(MUL_B_W-17){op_pd_q[16]}}, op_pd_q};
      end
      ST_MUL3: begin
        mul_a = acc_q;
        mul_b = {{(MUL_B_W-11){1'b0}}, freq_q};
      end
      ST_MUL4: begin
        mul_a = {{(MUL_A_W-17){op_d_q[16]}}, op_d_q};
        mul_b = US_PER_SEC;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // sign fix and divider step
  logic signed [NUM_W-1:0] num_abs;
  logic signed [DEN_W-1:0] den_abs;
  logic                    num_pos;
  logic                    div_ge;
  logic [COUNT_BITS-1:0]   q_fin;

  assign num_abs = den_q[DEN_W-1] ? -num_q : num_q;
  assign den_abs = den_q[DEN_W-1] ? -den_q : den_q;
  assign num_pos = !num_abs[NUM_W-1] && (num_abs != '0);
  assign div_ge  = rem_q >= {{(NUM_W-1-DVS_W){1'b0}}, dvs_q};
  assign q_fin   = {quo_q[COUNT_BITS-2:0], div_ge};

  logic             out_load;
  logic [CH_W-1:0]  res_idx;
  logic             res_in_range;

  assign res_idx      = res_ch_q[CH_W-1:0];
  assign res_in_range = {1'b0, res_ch_q} < CH_NUM;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        case (kind_e'(cmd_q.kind))
          KIND_SET_POS:    state_d = pos_go ? ST_MUL1 : ST_EMIT;
          KIND_SET_ENABLE: state_d = ST_EMIT;
          KIND_ESTOP:      state_d = ST_EMIT;
          KIND_CLEAR_STOP: state_d = ST_EMIT;
          KIND_CONFIGURE:  state_d = ST_EMIT;
          default:         state_d = ST_IDLE;
        endcase
      end
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_MUL3;
      ST_MUL3: state_d = ST_MUL4;
      ST_MUL4: state_d = ST_SIGN;
      ST_SIGN: state_d = num_pos ? ST_DIV : ST_EMIT;
      ST_DIV: begin
        if ((div_bit_q == 4'(COUNT_BITS) && div_ge) || div_bit_q == 4'd0) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_load && res_last_q) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o  = (state_q == ST_IDLE);
    cfg_ready_o = 1'b1;
    out_load    = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);
    out_valid_o = out_valid_q;
    out_item_o  = out_q;
  end

  // control and channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      freq_q      <= 11'd50;
      count_q     <= 5'd16;
      stop_q      <= 1'b0;
      inv_q       <= '0;
      en_q        <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        ang_lo_q[i] <= '0;
        ang_hi_q[i] <= '0;
        pls_lo_q[i] <= '0;
        pls_hi_q[i] <= '0;
        pos_q[i]    <= '0;
      end
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_PWM_FREQ:    freq_q  <= cfg_data_i;
          REG_SERVO_COUNT: count_q <= cfg_data_i[4:0];
          default: ;
        endcase
      end
      if (state_q == ST_DECODE) begin
        case (kind_e'(cmd_q.kind))
          KIND_SET_POS: begin
            if (pos_go) pos_q[id_idx] <= p_cl;
          end
          KIND_SET_ENABLE: begin
            if (id_in_range && !(stop_q && cmd_q.enable_flag)) begin
              en_q[id_idx] <= cmd_q.enable_flag;
            end
          end
          KIND_ESTOP: begin
            stop_q <= 1'b1;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
              if (5'(i) < used_cnt) en_q[i] <= 1'b0;
            end
          end
          KIND_CLEAR_STOP: stop_q <= 1'b0;
          KIND_CONFIGURE: begin
            if (id_in_range) begin
              ang_lo_q[id_idx] <= cmd_q.min_angle_in;
              ang_hi_q[id_idx] <= cmd_q.max_angle_in;
              pls_lo_q[id_idx] <= cmd_q.min_pulse_in;
              pls_hi_q[id_idx] <= cmd_q.max_pulse_in;
              inv_q[id_idx]    <= cmd_q.invert_in;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) cmd_q <= in_item_i;
    case (state_q)
      ST_DECODE: begin
        op_pmin_q  <= pls_lo_q[id_idx];
        op_diff_q  <= d_zero ? 18'sd0 : diff;
        op_d_q     <= d_zero ? 17'sd1 : dlt;
        op_pd_q    <= pdiff;
        res_ch_q   <= cmd_q.servo_id;
        res_wr_q   <= 1'b0;
        res_on_q   <= '0;
        res_off_q  <= '0;
        res_sts_q  <= STS_OK;
        res_last_q <= 1'b1;
        case (kind_e'(cmd_q.kind))
          KIND_SET_POS: begin
            if (!id_in_use) res_sts_q <= STS_BAD_ID;
            else if (stop_q) res_sts_q <= STS_STOP_ACTIVE;
            else if (!en_q[id_idx]) res_sts_q <= STS_NOT_ENABLED;
          end
          KIND_SET_ENABLE: begin
            if (!id_in_range) begin
              res_sts_q <= STS_BAD_ID;
            end else if (stop_q && cmd_q.enable_flag) begin
              res_sts_q <= STS_EN_REFUSED;
            end else if (!cmd_q.enable_flag) begin
              res_wr_q  <= 1'b1;
              res_off_q <= FULL_SCALE;
            end
          end
          KIND_ESTOP: begin
            res_ch_q   <= '0;
            res_wr_q   <= (used_cnt != 5'd0);
            res_off_q  <= (used_cnt != 5'd0) ? FULL_SCALE : 13'd0;
            res_last_q <= (used_cnt <= 5'd1);
          end
          KIND_CONFIGURE: begin
            if (!id_in_range) res_sts_q <= STS_BAD_ID;
          end
          default: ;
        endcase
      end
      ST_MUL1: acc_q <= mul_p[MUL_A_W-1:0];
      ST_MUL2: acc_q <= acc_q + mul_p[MUL_A_W-1:0];
      ST_MUL3: num_q <= {mul_p[NUM_W-COUNT_BITS-1:0], {COUNT_BITS{1'b0}}};
      ST_MUL4: den_q <= mul_p[DEN_W-1:0];
      ST_SIGN: begin
        rem_q     <= num_abs[NUM_W-2:0];
        dvs_q     <= {den_abs[DEN_W-2:0], {COUNT_BITS{1'b0}}};
        quo_q     <= '0;
        div_bit_q <= 4'(COUNT_BITS);
        res_wr_q  <= 1'b1;
        res_on_q  <= '0;
        res_off_q <= FULL_SCALE;
      end
      ST_DIV: begin
        if (div_ge) rem_q <= rem_q - {{(NUM_W-1-DVS_W){1'b0}}, dvs_q};
        dvs_q     <= dvs_q >> 1;
        quo_q     <= q_fin;
        div_bit_q <= div_bit_q - 4'd1;
        if (div_bit_q == 4'(COUNT_BITS) && div_ge) begin
          res_on_q  <= FULL_SCALE;
          res_off_q <= '0;
        end else if (div_bit_q == 4'd0) begin
          res_on_q  <= '0;
          res_off_q <= (q_fin == '0) ? FULL_SCALE : {1'b0, q_fin};
        end
      end
      ST_EMIT: begin
        if (out_load && !res_last_q) begin
          res_ch_q   <= res_ch_q + 4'd1;
          res_last_q <= ({1'b0, res_ch_q} + 5'd2 == used_cnt);
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_q.channel      <= res_ch_q;
      out_q.pwm_write    <= res_wr_q;
      out_q.on_count     <= res_on_q;
      out_q.off_count    <= res_off_q;
      out_q.status       <= res_sts_q;
      out_q.position_out <= res_in_range ? pos_q[res_idx] : 16'sd0;
      out_q.enabled_out  <= res_in_range && en_q[res_idx];
      out_q.stopped_out  <= stop_q;
      out_q.last         <= res_last_q;
    end
  end

`ifndef NO_ASSERTIONS
  a_idle_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.pwm_write) |->
      (out_item_o.on_count == 13'd0 && out_item_o.off_count == 13'd0))
    else $error("counts set without a pwm write");

  a_write_encoding: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.pwm_write) |->
      (out_item_o.on_count == 13'd0 || out_item_o.off_count == 13'd0))
    else $error("both on and off counts nonzero");

  a_stop_full_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.pwm_write && out_item_o.stopped_out) |->
      (out_item_o.off_count == FULL_SCALE))
    else $error("pwm drive other than full off while stopped");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second item taken while one is in flight");
`endif

endmodule

`default_nettype wire
